// ===== hw/rtl/ipid_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ipid_pkg;

	localparam int CountW = 16;
	localparam int ScaleW = 17;
	localparam int GainW  = 16;
	localparam int ErrW   = 18;
	localparam int D1W    = 19;
	localparam int D2W    = 20;
	localparam int OpAW   = 20;
	localparam int OpBW   = 18;
	localparam int ProdW  = OpAW + OpBW;
	localparam int SumW   = ProdW + 2;
	localparam int IncW   = SumW - 8;
	localparam int DriveW = 16;
	localparam int IdxW   = 2;
	localparam int CfgW   = 17;

	localparam logic [IdxW-1:0] REG_KP    = 2'd0;
	localparam logic [IdxW-1:0] REG_KI    = 2'd1;
	localparam logic [IdxW-1:0] REG_KD    = 2'd2;
	localparam logic [IdxW-1:0] REG_SCALE = 2'd3;

	localparam logic [ScaleW-1:0] SCALE_ONE = 17'h10000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE,
		ST_ERR,
		ST_KP,
		ST_KI,
		ST_KD,
		ST_ACC
	} state_t;

	typedef enum logic [1:0] {
		MUL_SCALE,
		MUL_KP,
		MUL_KI,
		MUL_KD
	} mul_sel_t;

	typedef struct packed {
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     sum_load;
		logic     sum_add;
		logic     err_load;
		logic     finish;
	} ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ipid_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ipid_mac (
	input  wire                                  clk,
	input  wire  ipid_pkg::ctrl_t                ctrl,
	input  wire  logic signed [ipid_pkg::OpAW-1:0]  op_a,
	input  wire  logic signed [ipid_pkg::OpBW-1:0]  op_b,
	output logic signed [ipid_pkg::ProdW-1:0]       product_q,
	output logic signed [ipid_pkg::SumW-1:0]        sum_q
);
	import ipid_pkg::*;

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			product_q <= op_a * op_b;
		end
		priority if (ctrl.sum_load) begin
			sum_q <= SumW'(product_q);
		end else if (ctrl.sum_add) begin
			sum_q <= sum_q + SumW'(product_q);
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ipid_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ipid_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	input  wire              out_free,
	output logic             in_ready,
	output ipid_pkg::ctrl_t  ctrl
);
	import ipid_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_SCALE;
			ST_SCALE: state_d = ST_ERR;
			ST_ERR:   state_d = ST_KP;
			ST_KP:    state_d = ST_KI;
			ST_KI:    state_d = ST_KD;
			ST_KD:    state_d = ST_ACC;
			ST_ACC:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		ctrl.mul_en   = 1'b0;
		ctrl.mul_sel  = MUL_SCALE;
		ctrl.sum_load = 1'b0;
		ctrl.sum_add  = 1'b0;
		ctrl.err_load = 1'b0;
		ctrl.finish   = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_SCALE: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MUL_SCALE;
			end
			ST_ERR: ctrl.err_load = 1'b1;
			ST_KP: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MUL_KP;
			end
			ST_KI: begin
				ctrl.mul_en   = 1'b1;
				ctrl.mul_sel  = MUL_KI;
				ctrl.sum_load = 1'b1;
			end
			ST_KD: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MUL_KD;
				ctrl.sum_add = 1'b1;
			end
			ST_ACC: ctrl.finish = out_free;
			default: in_ready = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/incremental_pid_speed_loop_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake              Payload
// s_axis   in         tvalid/tready          tdata: measured_count, speed_ref
// m_axis   out        tvalid/tready          tdata: drive_value; tuser: saturated
// cfg      in         cfg_we (no wait)       cfg_index, cfg_data
//
// Each accepted word passes through one scale multiply, an error step, three gain
// multiplies through the single shared 20x18 multiplier, then the accumulate and
// clamp step. The block takes no new word before it is through with the last one:
// a word is accepted only in idle.
// Reset clears gains, the stored previous errors and drive; the scale resets to 1.0.
// A result held on m_axis stalls the final step; the next word is taken once the
// block is back in idle, even while that result still waits.

module incremental_pid_speed_loop_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [31:0] s_axis_tdata,   // [15:0] measured_count, [31:16] speed_ref
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] drive_value
	output logic [0:0]  m_axis_tuser,   // [0] saturated
	input  wire         cfg_we,
	input  wire  [ipid_pkg::IdxW-1:0] cfg_index,
	input  wire  [ipid_pkg::CfgW-1:0] cfg_data
);
	import ipid_pkg::*;

	ctrl_t ctrl;
	logic  out_free;

	logic signed [GainW-1:0]  kp_q, ki_q, kd_q;
	logic        [ScaleW-1:0] scale_q;

	logic signed [CountW-1:0] count_q, target_q;
	logic signed [ErrW-1:0]   err_q, e1_q, e2_q;
	logic signed [D1W-1:0]    d1_q;
	logic signed [D2W-1:0]    d2_q;
	logic signed [DriveW-1:0] drive_q;

	logic signed [OpAW-1:0]   op_a;
	logic signed [OpBW-1:0]   op_b;
	logic signed [ProdW-1:0]  product_q;
	logic signed [SumW-1:0]   sum_q;

	logic signed [ProdW-1:0]  scaled_full;
	logic signed [ErrW-1:0]   err_new;
	logic signed [SumW-1:0]   total;
	logic signed [SumW-1:0]   total_rnd;
	logic signed [IncW-1:0]   inc;
	logic signed [IncW:0]     acc_raw;
	logic signed [DriveW-1:0] acc_sat;
	logic                     sat;

	logic out_valid_q;
	logic [DriveW-1:0] out_data_q;
	logic              out_sat_q;

	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q    <= '0;
			ki_q    <= '0;
			kd_q    <= '0;
			scale_q <= SCALE_ONE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KP:    kp_q    <= cfg_data[GainW-1:0];
				REG_KI:    ki_q    <= cfg_data[GainW-1:0];
				REG_KD:    kd_q    <= cfg_data[GainW-1:0];
				REG_SCALE: scale_q <= cfg_data[ScaleW-1:0];
				default:   kp_q    <= kp_q;
			endcase
		end
	end

	ipid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.out_free (out_free),
		.in_ready (s_axis_tready),
		.ctrl     (ctrl)
	);

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			count_q  <= s_axis_tdata[15:0];
			target_q <= s_axis_tdata[31:16];
		end
	end

	always_comb begin
		op_a = OpAW'(count_q);
		op_b = {1'b0, scale_q};
		unique case (ctrl.mul_sel)
			MUL_SCALE: begin
				op_a = OpAW'(count_q);
				op_b = {1'b0, scale_q};
			end
			MUL_KP: begin
				op_a = OpAW'(d1_q);
				op_b = OpBW'(kp_q);
			end
			MUL_KI: begin
				op_a = OpAW'(err_q);
				op_b = OpBW'(ki_q);
			end
			MUL_KD: begin
				op_a = d2_q;
				op_b = OpBW'(kd_q);
			end
			default: op_a = OpAW'(count_q);
		endcase
	end

	ipid_mac u_mac (
		.clk       (clk),
		.ctrl      (ctrl),
		.op_a      (op_a),
		.op_b      (op_b),
		.product_q (product_q),
		.sum_q     (sum_q)
	);

	assign scaled_full = (product_q + ProdW'(32768)) >>> 16;
	assign err_new     = ErrW'(target_q) - scaled_full[ErrW-1:0];

	always_ff @(posedge clk) begin
		if (ctrl.err_load) begin
			err_q <= err_new;
			d1_q  <= D1W'(err_new) - D1W'(e1_q);
			d2_q  <= D2W'(err_new) - (D2W'(e1_q) <<< 1) + D2W'(e2_q);
		end
	end

	assign total     = sum_q + SumW'(product_q);
	assign total_rnd = (total + SumW'(128)) >>> 8;
	assign inc       = total_rnd[IncW-1:0];
	assign acc_raw   = (IncW+1)'(drive_q) + (IncW+1)'(inc);

	always_comb begin
		acc_sat = acc_raw[DriveW-1:0];
		sat     = 1'b0;
		priority if (acc_raw > (IncW+1)'(32767)) begin
			acc_sat = 16'sh7FFF;
			sat     = 1'b1;
		end else if (acc_raw < -(IncW+1)'(32768)) begin
			acc_sat = 16'sh8000;
			sat     = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q <= '0;
			e1_q    <= '0;
			e2_q    <= '0;
		end else if (ctrl.finish) begin
			drive_q <= acc_sat;
			e1_q    <= err_q;
			e2_q    <= e1_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.finish) begin
			out_data_q <= acc_sat;
			out_sat_q  <= sat;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_data_q;
	assign m_axis_tuser[0] = out_sat_q;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import ipid_pkg::*;

	localparam int StallLimit  = 4000;
	localparam int DrainCycles = 8;
	localparam int PhaseCount  = 8;
	localparam int PhaseWords  = 128;

	typedef struct packed {
		logic [DriveW-1:0] drive;
		logic              sat;
	} drive_word_t;

	typedef struct {
		bit                 is_cfg;
		logic [IdxW-1:0]    idx;
		logic [CfgW-1:0]    val;
		logic signed [15:0] count;
		logic signed [15:0] target;
		bit                 known;
		logic signed [15:0] drive;
		bit                 sat;
	} plan_row_t;

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [31:0]      s_axis_tdata;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [15:0]      m_axis_tdata;
	logic [0:0]       m_axis_tuser;
	logic             cfg_we;
	logic [IdxW-1:0]  cfg_index;
	logic [CfgW-1:0]  cfg_data;

	logic signed [GainW-1:0]  kp_q, ki_q, kd_q;
	logic [ScaleW-1:0]        scale_q;
	logic signed [ErrW-1:0]   err_prev, err_older;
	logic signed [DriveW-1:0] drive_acc;

	drive_word_t drive_expected[$];
	plan_row_t   plan [0:38];
	int          mismatches;
	int          stall_cycles;
	bit          steady;

	incremental_pid_speed_loop_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic drive_word_t speed_loop_step(logic signed [15:0] count,
			logic signed [15:0] target);
		longint scaled, err, e1, e2, sum, inc, acc;
		drive_word_t w;
		scaled = (longint'(count) * longint'({1'b0, scale_q}) + 64'sd32768) >>> 16;
		err = longint'(target) - scaled;
		e1 = longint'(err_prev);
		e2 = longint'(err_older);
		sum = longint'(kp_q) * (err - e1) + longint'(ki_q) * err
			+ longint'(kd_q) * (err - 2 * e1 + e2);
		inc = (sum + 64'sd128) >>> 8;
		acc = longint'(drive_acc) + inc;
		w.sat = 1'b0;
		if (acc > 64'sd32767) begin
			acc = 64'sd32767;
			w.sat = 1'b1;
		end else if (acc < -64'sd32768) begin
			acc = -64'sd32768;
			w.sat = 1'b1;
		end
		drive_acc = acc[15:0];
		err_older = err_prev;
		err_prev = err[17:0];
		w.drive = acc[15:0];
		return w;
	endfunction

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(4))
			0: return 16'($urandom);
			1: return 16'h7FFF;
			2: return 16'h8000;
			default: return 16'(int'($urandom_range(1023)) - 512);
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < 100)
			$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (drive_expected.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_KP:    kp_q = val[15:0];
			REG_KI:    ki_q = val[15:0];
			REG_KD:    kd_q = val[15:0];
			REG_SCALE: scale_q = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_word(input logic signed [15:0] count, input logic signed [15:0] target,
			input bit known, input logic signed [15:0] drive, input bit sat);
		drive_word_t w;
		while (!steady && $urandom_range(99) < 38) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {target, count};
		do @(posedge clk); while (!s_axis_tready);
		w = speed_loop_step(count, target);
		if (known) begin
			w.drive = drive;
			w.sat = sat;
		end
		drive_expected.push_back(w);
	endtask

	always @(posedge clk) begin
		m_axis_tready <= steady || ($urandom_range(99) >= 38);
	end

	always @(posedge clk) begin : check_out
		drive_word_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (drive_expected.size() == 0) begin
				report_mismatch($sformatf("unexpected word drive=%0d sat=%0d",
					$signed(m_axis_tdata), m_axis_tuser[0]));
			end else begin
				want = drive_expected.pop_front();
				if (m_axis_tdata !== want.drive)
					report_mismatch($sformatf("drive_value got %0d want %0d",
						$signed(m_axis_tdata), $signed(want.drive)));
				if (m_axis_tuser[0] !== want.sat)
					report_mismatch($sformatf("saturated got %0d want %0d",
						m_axis_tuser[0], want.sat));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= StallLimit) begin
			$display("timeout: no word moved for %0d cycles", StallLimit);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin : stimulus
		int                 phase;
		int                 n;
		int                 hold_left;
		logic signed [15:0] tgt;
		logic signed [15:0] cnt;
		logic [ScaleW-1:0]  scale_pick;

		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		m_axis_tready <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_KP;
		cfg_data <= '0;
		arst_n <= 1'b0;
		kp_q = '0;
		ki_q = '0;
		kd_q = '0;
		scale_q = SCALE_ONE;
		err_prev = '0;
		err_older = '0;
		drive_acc = '0;
		mismatches = 0;
		stall_cycles = 0;
		steady = 1'b0;
		hold_left = 0;
		tgt = '0;

		plan = '{
			'{1'b0, REG_KP, 17'h0, 16'h8000, 16'h7FFF, 1'b1, 16'h0000, 1'b0},
			'{1'b0, REG_KP, 17'h0, 16'h7FFF, 16'h8000, 1'b1, 16'h0000, 1'b0},
			'{1'b0, REG_KP, 17'h0, 16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b0},
			'{1'b1, REG_KI, 17'h00100, 16'h0, 16'h0, 1'b0, 16'h0, 1'b0},
			'{1'b0, REG_KP, 17'h0, 16'h0000, 16'd100, 1'b1, 16'd100, 1'b0},
			'{1'b1, REG_KI, 17'h07FFF, 16'h0, 16'h0, 1'b0, 16'h0, 1'b0},
			'{1'b0, REG_KP, 17'h0, 16'h8000, 16'h7FFF, 1'b1, 16'h7FFF, 1'b1},
			'{1'b0, REG_KP, 17'h0, 16'h7FFF, 16'h8000, 1'b1, 16'h8000, 1'b1},
			'{1'b1, REG_KI, 17'h08000, 16'h0, 16'h0, 1'b0, 16'h0, 1'b0},
			'{1'b0, REG_KP, 17'h0, 16'h7FFF, 16'h8000, 1'b1, 16'h7FFF, 1'b1},
			'{1'b1, REG_KI, 17'h00000, 16'h0, 16'h0, 1'b0, 16'h0, 1'b0},
			'{1'b1, REG_KP, 17'h08000, 16'h0, 16'h0, 1'b0, 16'h0, 1'b0},
			'{1'b0, REG_KP, 17'h0, 16'h0000, 16'h0000, 1'b1, 16'h8000, 1'b1},
			'{1'b1, REG_KP, 17'h07FFF, 16'h0, 16'h0, 1'b0, 16'h0, 1'b0},
			'{1'b0, REG_KP, 17'h0, 16'h0000, 16'h7FFF, 1'b1, 16'h7FFF, 1'b1},
			'{1'b1, REG_KP, 17'h00000, 16'h0, 16'h0, 1'b0, 16'h0, 1'b0},
			'{1'b1, REG_KD, 17'h07FFF, 16'h0, 16'h0, 1'b0, 16'h0, 1'b0},
			'{1'b0, REG_KP, 17'h0, 16'h0000, 16'h8000, 1'b1, 16'h8000, 1'b1},
			'{1'b1, REG_KD, 17'h08000, 16'h0, 16'h0, 1'b0, 16'h0, 1'b0},
			'{1'b0, REG_KP, 17'h0, 16'h7FFF, 16'h7FFF, 1'b1, 16'h8000, 1'b1},
			'{1'b1, REG_KD, 17'h00040, 16'h0, 16'h0, 1'b0, 16'h0, 1'b0},
			'{1'b1, REG_KP, 17'h00180, 16'h0, 16'h0, 1'b0, 16'h0, 1'b0},
			'{1'b1, REG_KI, 17'h00080, 16'h0, 16'h0, 1'b0, 16'h0, 1'b0},
			'{1'b1, REG_SCALE, 17'h08000, 16'h0, 16'h0, 1'b0, 16'h0, 1'b0},
			'{1'b0, REG_KP, 17'h0, 16'h0001, 16'h0000, 1'b0, 16'h0, 1'b0},
			'{1'b0, REG_KP, 17'h0, 16'hFFFF, 16'h0000, 1'b0, 16'h0, 1'b0},
			'{1'b0, REG_KP, 17'h0, 16'h0003, 16'h0001, 1'b0, 16'h0, 1'b0},
			'{1'b1, REG_SCALE, 17'd22141, 16'h0, 16'h0, 1'b0, 16'h0, 1'b0},
			'{1'b0, REG_KP, 17'h0, 16'd296, 16'd100, 1'b0, 16'h0, 1'b0},
			'{1'b0, REG_KP, 17'h0, 16'h8000, 16'h0000, 1'b0, 16'h0, 1'b0},
			'{1'b1, REG_SCALE, 17'd23918, 16'h0, 16'h0, 1'b0, 16'h0, 1'b0},
			'{1'b0, REG_KP, 17'h0, 16'd274, 16'hFF9C, 1'b0, 16'h0, 1'b0},
			'{1'b1, REG_SCALE, 17'h1FFFF, 16'h0, 16'h0, 1'b0, 16'h0, 1'b0},
			'{1'b0, REG_KP, 17'h0, 16'h8000, 16'h7FFF, 1'b0, 16'h0, 1'b0},
			'{1'b0, REG_KP, 17'h0, 16'h7FFF, 16'h8000, 1'b0, 16'h0, 1'b0},
			'{1'b1, REG_SCALE, 17'h00000, 16'h0, 16'h0, 1'b0, 16'h0, 1'b0},
			'{1'b0, REG_KP, 17'h0, 16'd12345, 16'hFFF9, 1'b0, 16'h0, 1'b0},
			'{1'b1, REG_SCALE, SCALE_ONE, 16'h0, 16'h0, 1'b0, 16'h0, 1'b0},
			'{1'b0, REG_KP, 17'h0, 16'h0000, 16'h0001, 1'b0, 16'h0, 1'b0}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		wait_idle();

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				wait_idle();
				write_reg(plan[i].idx, plan[i].val);
			end else begin
				send_word(plan[i].count, plan[i].target, plan[i].known,
					plan[i].drive, plan[i].sat);
			end
		end

		for (phase = 0; phase < PhaseCount; phase++) begin
			wait_idle();
			steady = (phase == 3);
			case ($urandom_range(5))
				0: scale_pick = SCALE_ONE;
				1: scale_pick = 17'd22141;
				2: scale_pick = 17'd23918;
				3: scale_pick = 17'h00000;
				4: scale_pick = 17'h1FFFF;
				default: scale_pick = 17'($urandom);
			endcase
			write_reg(REG_KP, {1'b0, pick_gain()});
			write_reg(REG_KI, {1'b0, pick_gain()});
			write_reg(REG_KD, {1'b0, pick_gain()});
			write_reg(REG_SCALE, scale_pick);
			for (n = 0; n < PhaseWords; n++) begin
				if ($urandom_range(3) == 0) begin
					cnt = 16'($urandom);
					send_word(cnt, 16'($urandom), 1'b0, 16'sd0, 1'b0);
				end else begin
					if (hold_left == 0) begin
						if ($urandom_range(3) == 0)
							tgt = 16'($urandom);
						else
							tgt = 16'(int'($urandom_range(4000)) - 2000);
						hold_left = $urandom_range(24, 4);
					end
					hold_left--;
					cnt = 16'(int'(tgt) + int'($urandom_range(128)) - 64);
					send_word(cnt, tgt, 1'b0, 16'sd0, 1'b0);
				end
			end
		end
		steady = 1'b0;

		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/ipid_pkg.sv
hw/rtl/ipid_mac.sv
hw/rtl/ipid_ctrl.sv
hw/rtl/incremental_pid_speed_loop_top.sv
test/testbench.sv
